// ===== src/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, codes and helper functions for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int MAX_WORD_LEN = 32;
    localparam int FRAC_LIMIT   = 48;
    localparam int CFG_W        = 6;
    localparam int IDX_W        = 3;
    localparam int OPD_W        = 32;
    localparam int ACC_W        = OPD_W + 2;
    localparam int RES_W        = 64;
    localparam int RW_W         = 7;
    localparam int LEN_W        = 6;

    localparam logic [CFG_W-1:0] RST_WORD_LEN = 6'd16;
    localparam logic [CFG_W-1:0] RST_FRAC_LEN = 6'd8;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_SUB  = 2'd1,
        REQ_MUL  = 2'd2,
        REQ_CONV = 2'd3
    } t_req;

    typedef enum logic [IDX_W-1:0] {
        CFG_A_WORD_LEN    = 3'd0,
        CFG_A_FRAC_LEN    = 3'd1,
        CFG_B_WORD_LEN    = 3'd2,
        CFG_B_FRAC_LEN    = 3'd3,
        CFG_DST_WORD_LEN  = 3'd4,
        CFG_DST_FRAC_LEN  = 3'd5,
        CFG_QUANT_MODE    = 3'd6,
        CFG_OVERFLOW_MODE = 3'd7
    } t_cfg_idx;

    // clamped formats, ready to use
    typedef struct packed {
        logic [CFG_W-1:0] a_word_len;
        logic [CFG_W-1:0] a_frac_len;
        logic [CFG_W-1:0] b_word_len;
        logic [CFG_W-1:0] b_frac_len;
        logic [CFG_W-1:0] dst_word_len;
        logic [CFG_W-1:0] dst_frac_len;
        logic             quant_mode;
        logic             overflow_mode;
    } t_cfg;

    typedef struct packed {
        logic signed [ACC_W-1:0] val;
        logic                    rup;
    } t_rnd;

    // sign-extend x from its low w bits (w in 1..64)
    function automatic logic [RES_W-1:0] sext_var(input logic [RES_W-1:0] x,
                                                  input logic [RW_W-1:0] w);
        logic [RES_W-1:0] mask;
        logic [5:0]       top;
        mask = (RES_W'(1) << w) - RES_W'(1);
        top  = 6'(w - RW_W'(1));
        sext_var = x[top] ? (x | ~mask) : (x & mask);
    endfunction

    // most positive or most negative value of width w
    function automatic logic [RES_W-1:0] sat_val(input logic [RW_W-1:0] w,
                                                 input logic neg);
        logic [RES_W-1:0] mx;
        mx = (RES_W'(1) << 6'(w - RW_W'(1))) - RES_W'(1);
        sat_val = neg ? ~mx : mx;
    endfunction

    // arithmetic right shift by d, truncating or rounding half up
    function automatic t_rnd rshift_round(input logic signed [ACC_W-1:0] v,
                                          input logic [CFG_W-1:0] d,
                                          input logic qm);
        logic signed [ACC_W-1:0] t;
        t_rnd                    r;
        t = v >>> (d - CFG_W'(1));
        if (d == '0) begin
            r.val = v;
            r.rup = 1'b0;
        end else if (qm) begin
            r.val = (t >>> 1) + $signed(ACC_W'(t[0]));
            r.rup = t[0];
        end else begin
            r.val = v >>> d;
            r.rup = 1'b0;
        end
        rshift_round = r;
    endfunction

endpackage

// ===== src/fpa_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_cfg
// Configuration register file with range clamping of the format fields.
// ----------------------------------------------------------------------------
module fpa_cfg import fpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    logic [CFG_W-1:0] r_a_word, r_a_frac, r_b_word, r_b_frac, r_d_word, r_d_frac;
    logic             r_quant, r_ovf_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_word   <= RST_WORD_LEN;
            r_a_frac   <= RST_FRAC_LEN;
            r_b_word   <= RST_WORD_LEN;
            r_b_frac   <= RST_FRAC_LEN;
            r_d_word   <= RST_WORD_LEN;
            r_d_frac   <= RST_FRAC_LEN;
            r_quant    <= 1'b0;
            r_ovf_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_A_WORD_LEN:    r_a_word   <= i_cfg_data;
                CFG_A_FRAC_LEN:    r_a_frac   <= i_cfg_data;
                CFG_B_WORD_LEN:    r_b_word   <= i_cfg_data;
                CFG_B_FRAC_LEN:    r_b_frac   <= i_cfg_data;
                CFG_DST_WORD_LEN:  r_d_word   <= i_cfg_data;
                CFG_DST_FRAC_LEN:  r_d_frac   <= i_cfg_data;
                CFG_QUANT_MODE:    r_quant    <= i_cfg_data[0];
                CFG_OVERFLOW_MODE: r_ovf_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [CFG_W-1:0] word_of(input logic [CFG_W-1:0] r);
        if (r == '0) begin
            word_of = CFG_W'(1);
        end else if (r > CFG_W'(MAX_WORD_LEN)) begin
            word_of = CFG_W'(MAX_WORD_LEN);
        end else begin
            word_of = r;
        end
    endfunction

    function automatic logic [CFG_W-1:0] frac_of(input logic [CFG_W-1:0] r);
        frac_of = (r > CFG_W'(FRAC_LIMIT)) ? CFG_W'(FRAC_LIMIT) : r;
    endfunction

    always_comb begin
        o_cfg.a_word_len    = word_of(r_a_word);
        o_cfg.a_frac_len    = frac_of(r_a_frac);
        o_cfg.b_word_len    = word_of(r_b_word);
        o_cfg.b_frac_len    = frac_of(r_b_frac);
        o_cfg.dst_word_len  = word_of(r_d_word);
        o_cfg.dst_frac_len  = frac_of(r_d_frac);
        o_cfg.quant_mode    = r_quant;
        o_cfg.overflow_mode = r_ovf_mode;
    end

endmodule

// ===== src/fixed_point_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Fixed-point add, subtract, multiply and requantize with round and saturate.
// ----------------------------------------------------------------------------
// One operation is taken in every clock cycle (start while busy is low) and
// its word comes out on o_strobe once it has passed all the stages; busy is only high
// during reset. The four register stages are operand capture and sign
// extension, operand alignment / 32x32 multiply / convert shift, the
// overflow-checked sum and leading-one search, and result formatting. The
// receiver has no way to hold results off: each word is shown for one cycle.
// Format registers may be written only when no operation is in flight.
module fixed_point_alu import fpa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic [1:0]              i_req_type,
    input  logic signed [OPD_W-1:0] i_a_value,
    input  logic signed [OPD_W-1:0] i_b_value,
    output logic                    o_strobe,
    output logic signed [RES_W-1:0] o_result_value,
    output logic [RW_W-1:0]         o_result_width,
    output logic [CFG_W-1:0]        o_result_frac,
    output logic                    o_overflow,
    output logic                    o_rounded_up,
    output logic                    o_precision_lost
);

    t_cfg cfg;

    fpa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign busy = !i_rst_n;

    // valid bits
    logic r_v1, r_v2, r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_v1     <= start && !busy;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            o_strobe <= r_v3;
        end
    end

    // ---------------- stage 1: capture, sign-extend operands
    t_req                    r_s1_req;
    logic signed [OPD_W-1:0] r_s1_a, r_s1_b;

    always_ff @(posedge i_clk) begin
        r_s1_req <= t_req'(i_req_type);
        r_s1_a   <= OPD_W'(sext_var(RES_W'(i_a_value), RW_W'(cfg.a_word_len)));
        r_s1_b   <= OPD_W'(sext_var(RES_W'(i_b_value), RW_W'(cfg.b_word_len)));
    end

    // ---------------- stage 2: align, multiply, convert shift
    logic [CFG_W-1:0]        as_frac, da, db, dc;
    logic signed [ACC_W-1:0] a_ext, b_ext, b_op;
    t_rnd                    rnd_a, rnd_b, rnd_c;
    logic [OPD_W-1:0]        n_s2_cv, n_s2_mag;
    logic                    n_s2_rup, n_s2_plost;

    always_comb begin
        as_frac = (cfg.a_frac_len < cfg.b_frac_len) ? cfg.a_frac_len : cfg.b_frac_len;
        da      = cfg.a_frac_len - as_frac;
        db      = cfg.b_frac_len - as_frac;
        a_ext   = ACC_W'(r_s1_a);
        b_ext   = ACC_W'(r_s1_b);
        b_op    = (r_s1_req == REQ_SUB) ? -b_ext : b_ext;
        rnd_a   = rshift_round(a_ext, da, cfg.quant_mode);
        rnd_b   = rshift_round(b_op, db, cfg.quant_mode);

        dc      = (cfg.dst_frac_len < cfg.a_frac_len) ?
                  (cfg.a_frac_len - cfg.dst_frac_len) : '0;
        rnd_c   = rshift_round(a_ext, dc, cfg.quant_mode);
        if (cfg.dst_frac_len >= cfg.a_frac_len) begin
            n_s2_cv = OPD_W'(r_s1_a) << (cfg.dst_frac_len - cfg.a_frac_len);
        end else begin
            n_s2_cv = rnd_c.val[OPD_W-1:0];
        end
        // most negative input maps to its unsigned magnitude
        n_s2_mag = r_s1_a[OPD_W-1] ? (~OPD_W'(r_s1_a) + OPD_W'(1)) : OPD_W'(r_s1_a);

        case (r_s1_req) inside
            REQ_ADD, REQ_SUB: begin
                n_s2_rup   = rnd_a.rup | rnd_b.rup;
                n_s2_plost = (cfg.a_frac_len != cfg.b_frac_len);
            end
            REQ_CONV: begin
                n_s2_rup   = rnd_c.rup;
                n_s2_plost = (cfg.dst_frac_len < cfg.a_frac_len);
            end
            default: begin
                n_s2_rup   = 1'b0;
                n_s2_plost = 1'b0;
            end
        endcase
    end

    t_req                    r_s2_req;
    logic signed [ACC_W-1:0] r_s2_l, r_s2_r;
    logic signed [RES_W-1:0] r_s2_prod;
    logic [OPD_W-1:0]        r_s2_cv, r_s2_mag;
    logic                    r_s2_rup, r_s2_plost, r_s2_neg;

    always_ff @(posedge i_clk) begin
        r_s2_req   <= r_s1_req;
        r_s2_l     <= rnd_a.val;
        r_s2_r     <= rnd_b.val;
        r_s2_prod  <= RES_W'(r_s1_a) * RES_W'(r_s1_b);
        r_s2_cv    <= n_s2_cv;
        r_s2_mag   <= n_s2_mag;
        r_s2_rup   <= n_s2_rup;
        r_s2_plost <= n_s2_plost;
        r_s2_neg   <= r_s1_a[OPD_W-1];
    end

    // ---------------- stage 3: sum with overflow, leading-one search
    logic [CFG_W-1:0]        as_max;
    logic [RW_W-1:0]         as_width;
    logic signed [ACC_W:0]   sum;
    logic [RES_W-1:0]        sum_wrap;
    logic                    as_ovf;
    logic [RES_W-1:0]        n_s3_res;
    logic                    n_s3_ovf;
    logic [LEN_W-1:0]        n_s3_len;

    always_comb begin
        as_max   = (cfg.a_word_len > cfg.b_word_len) ? cfg.a_word_len : cfg.b_word_len;
        as_width = RW_W'(as_max) + RW_W'(1);
        sum      = (ACC_W+1)'(r_s2_l) + (ACC_W+1)'(r_s2_r);
        sum_wrap = sext_var(RES_W'(sum), as_width);
        // sign change when both operands share a sign
        as_ovf   = (r_s2_l[ACC_W-1] == r_s2_r[ACC_W-1]) &&
                   (sum_wrap[RES_W-1] != r_s2_l[ACC_W-1]);

        if (r_s2_req == REQ_MUL) begin
            n_s3_res = r_s2_prod;
            n_s3_ovf = 1'b0;
        end else begin
            n_s3_res = (as_ovf && cfg.overflow_mode) ?
                       sat_val(as_width, r_s2_l[ACC_W-1]) : sum_wrap;
            n_s3_ovf = as_ovf;
        end

        n_s3_len = '0;
        for (int i = 0; i < OPD_W; i++) begin
            if (r_s2_mag[i]) n_s3_len = LEN_W'(i + 1);
        end
    end

    t_req             r_s3_req;
    logic [RES_W-1:0] r_s3_res;
    logic [OPD_W-1:0] r_s3_cv;
    logic [LEN_W-1:0] r_s3_len;
    logic             r_s3_ovf, r_s3_rup, r_s3_plost, r_s3_neg, r_s3_nz;

    always_ff @(posedge i_clk) begin
        r_s3_req   <= r_s2_req;
        r_s3_res   <= n_s3_res;
        r_s3_cv    <= r_s2_cv;
        r_s3_len   <= n_s3_len;
        r_s3_ovf   <= n_s3_ovf;
        r_s3_rup   <= r_s2_rup;
        r_s3_plost <= r_s2_plost;
        r_s3_neg   <= r_s2_neg;
        r_s3_nz    <= (r_s2_mag != '0);
    end

    // ---------------- stage 4: result formatting
    logic [RW_W-1:0]  mul_frac_sum;
    logic [RW_W-1:0]  dst_width;
    logic             cv_ovf;
    logic [RES_W-1:0] n_value;
    logic [RW_W-1:0]  n_width;
    logic [CFG_W-1:0] n_frac;
    logic             n_ovf;

    always_comb begin
        mul_frac_sum = RW_W'(cfg.a_frac_len) + RW_W'(cfg.b_frac_len);
        dst_width    = RW_W'(cfg.dst_word_len);
        // integer bits needed exceed integer bits available
        cv_ovf = r_s3_nz &&
                 ((8'(r_s3_len) + 8'(cfg.dst_frac_len) + 8'd1) >
                  (8'(cfg.dst_word_len) + 8'(cfg.a_frac_len)));

        case (r_s3_req) inside
            REQ_ADD, REQ_SUB: begin
                n_value = r_s3_res;
                n_width = as_width;
                n_frac  = as_frac;
                n_ovf   = r_s3_ovf;
            end
            REQ_MUL: begin
                n_value = r_s3_res;
                n_width = RW_W'(cfg.a_word_len) + RW_W'(cfg.b_word_len);
                n_frac  = (mul_frac_sum > RW_W'(63)) ? CFG_W'(63) : mul_frac_sum[CFG_W-1:0];
                n_ovf   = 1'b0;
            end
            default: begin
                n_value = (cv_ovf && cfg.overflow_mode) ? sat_val(dst_width, r_s3_neg)
                                                        : sext_var(RES_W'(r_s3_cv), dst_width);
                n_width = dst_width;
                n_frac  = cfg.dst_frac_len;
                n_ovf   = cv_ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_result_value   <= n_value;
        o_result_width   <= n_width;
        o_result_frac    <= n_frac;
        o_overflow       <= n_ovf;
        o_rounded_up     <= r_s3_rup;
        o_precision_lost <= r_s3_plost;
    end

    // ---------------- checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted word did not appear four cycles later");

    a_mul_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_width > RW_W'(33)) |->
        (!o_overflow && !o_rounded_up && !o_precision_lost))
        else $error("product word carries a status flag");

    a_round_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rounded_up) |-> o_precision_lost)
        else $error("round-up without dropped fraction bits");

    a_sext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result_value == sext_var(o_result_value, o_result_width)))
        else $error("result not sign-extended from its width");

endmodule
